>>> rtl/bipd_pkg.sv
// ----------------------------------------------------------------------------
// bipd_pkg: shared types and codes for the branch instruction predecoder
// Group selectors, branch and test kinds, and the decoded result record.
// ----------------------------------------------------------------------------
package bipd_pkg;

	localparam int unsigned WORD_W = 32;
	localparam int unsigned ADDR_W = 64;

	// group selector on the input tuser
	localparam logic [2:0] GRP_IMM    = 3'd0;
	localparam logic [2:0] GRP_CMP    = 3'd1;
	localparam logic [2:0] GRP_TST    = 3'd2;
	localparam logic [2:0] GRP_COND   = 3'd3;
	localparam logic [2:0] GRP_REG    = 3'd4;
	localparam logic [2:0] GRP_REGLNK = 3'd5;

	localparam logic [2:0] KIND_UNCOND   = 3'd0;
	localparam logic [2:0] KIND_CALL     = 3'd1;
	localparam logic [2:0] KIND_COND     = 3'd2;
	localparam logic [2:0] KIND_IND_JUMP = 3'd3;
	localparam logic [2:0] KIND_IND_CALL = 3'd4;
	localparam logic [2:0] KIND_RETURN   = 3'd5;

	localparam logic [2:0] TEST_NONE    = 3'd0;
	localparam logic [2:0] TEST_ZERO    = 3'd1;
	localparam logic [2:0] TEST_NONZERO = 3'd2;
	localparam logic [2:0] TEST_BIT_Z   = 3'd3;
	localparam logic [2:0] TEST_BIT_NZ  = 3'd4;
	localparam logic [2:0] TEST_FLAGS   = 3'd5;

	localparam logic [1:0] OP_JUMP   = 2'd0;
	localparam logic [1:0] OP_CALL   = 2'd1;
	localparam logic [1:0] OP_RETURN = 2'd2;
	localparam logic [1:0] OP_RSVD   = 2'd3;

	localparam logic [3:0] COND_ALWAYS_FIRST = 4'he;

	typedef struct packed {
		logic              unallocated;
		logic [2:0]        branch_kind;
		logic [ADDR_W-1:0] target;
		logic [2:0]        test_kind;
		logic [3:0]        cond_code;
		logic [4:0]        source_reg;
		logic              wide_reg;
		logic [ADDR_W-1:0] test_mask;
		logic              writes_link;
		logic [ADDR_W-1:0] link_value;
	} bipd_result_t;

endpackage

>>> rtl/branch_instruction_predecode_core.sv
// ----------------------------------------------------------------------------
// branch_instruction_predecode_core: A64 branch predecoder, stream in/out
// Input register, then combinational decode and adds, then result register.
// Throughput: one instruction per cycle while the output accepts results; the
// result register and the input register advance independently, so a
// stalled result blocks only when both are full. Reset clears both valid
// flags; payload registers are not reset.
// ----------------------------------------------------------------------------
module branch_instruction_predecode_core import bipd_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	input  logic [95:0]  s_axis_tdata,  // instruction_word[31:0], pc[95:32]
	input  logic [2:0]   s_axis_tuser,  // action[2:0]
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	// target[63:0], test_kind[66:64], cond_code[70:67], source_reg[75:71],
	// wide_reg[76], test_mask[140:77], writes_link[141], link_value[205:142],
	// zero pad[207:206]
	output logic [207:0] m_axis_tdata,
	output logic [3:0]   m_axis_tuser   // unallocated[0], branch_kind[3:1]
);

	logic              valid_s1;
	logic [2:0]        action_s1;
	logic [WORD_W-1:0] word_s1;
	logic [ADDR_W-1:0] pc_s1;
	logic              valid_s2;
	bipd_result_t      result_s2;
	bipd_result_t      decoded;
	logic              advance_s1;

	assign advance_s1    = !valid_s2 || m_axis_tready;
	assign s_axis_tready = !valid_s1 || advance_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (s_axis_tready) begin
				valid_s1 <= s_axis_tvalid;
			end
			if (advance_s1) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			action_s1 <= s_axis_tuser;
			word_s1   <= s_axis_tdata[31:0];
			pc_s1     <= s_axis_tdata[95:32];
		end
		if (valid_s1 && advance_s1) begin
			result_s2 <= decoded;
		end
	end

	bipd_decode u_decode (
		.action           (action_s1),
		.instruction_word (word_s1),
		.pc               (pc_s1),
		.result           (decoded)
	);

	assign m_axis_tvalid = valid_s2;
	assign m_axis_tuser  = {result_s2.branch_kind, result_s2.unallocated};
	assign m_axis_tdata  = {2'b00,
	                        result_s2.link_value,
	                        result_s2.writes_link,
	                        result_s2.test_mask,
	                        result_s2.wide_reg,
	                        result_s2.source_reg,
	                        result_s2.cond_code,
	                        result_s2.test_kind,
	                        result_s2.target};

	a_ready_when_out_free: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s2 |-> s_axis_tready)
		else $error("input not ready while result register empty");

	a_unalloc_clears_link: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && result_s2.unallocated) |->
		(result_s2.link_value == '0 && result_s2.branch_kind == KIND_UNCOND))
		else $error("reserved encoding carries decoded fields");

	a_bit_test_mask: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && (result_s2.test_kind == TEST_BIT_Z || result_s2.test_kind == TEST_BIT_NZ))
		|-> $onehot(result_s2.test_mask))
		else $error("bit test without one-hot mask");

	a_cond_code_flags: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && result_s2.cond_code != 4'd0) |-> (result_s2.test_kind == TEST_FLAGS))
		else $error("condition code on non-flag test");

endmodule

>>> rtl/bipd_decode.sv
// ----------------------------------------------------------------------------
// bipd_decode: combinational A64 branch field decode
// Extracts kind, condition test, registers and mask, and forms return address
// and, for direct groups, target from one registered instruction.
// ----------------------------------------------------------------------------
module bipd_decode import bipd_pkg::*; (
	input  logic [2:0]        action,
	input  logic [WORD_W-1:0] instruction_word,
	input  logic [ADDR_W-1:0] pc,
	output bipd_result_t      result
);

	logic [ADDR_W-1:0] off26;
	logic [ADDR_W-1:0] off19;
	logic [ADDR_W-1:0] off14;
	logic [ADDR_W-1:0] offset;
	logic [5:0]        bit_pos;
	logic [1:0]        op;
	logic [3:0]        cc;

	assign off26   = {{(ADDR_W-28){instruction_word[25]}}, instruction_word[25:0], 2'b00};
	assign off19   = {{(ADDR_W-21){instruction_word[23]}}, instruction_word[23:5], 2'b00};
	assign off14   = {{(ADDR_W-16){instruction_word[18]}}, instruction_word[18:5], 2'b00};
	assign bit_pos = {instruction_word[31], instruction_word[23:19]};
	assign op      = instruction_word[22:21];
	assign cc      = instruction_word[3:0];

	always_comb begin
		result             = '0;
		offset             = '0;
		result.link_value  = pc + ADDR_W'(4);
		case (action)
			GRP_IMM: begin
				offset             = off26;
				result.writes_link = instruction_word[31];
				result.branch_kind = instruction_word[31] ? KIND_CALL : KIND_UNCOND;
			end
			GRP_CMP: begin
				offset             = off19;
				result.branch_kind = KIND_COND;
				result.test_kind   = instruction_word[24] ? TEST_NONZERO : TEST_ZERO;
				result.source_reg  = instruction_word[4:0];
				result.wide_reg    = instruction_word[31];
			end
			GRP_TST: begin
				offset             = off14;
				result.branch_kind = KIND_COND;
				result.test_kind   = instruction_word[24] ? TEST_BIT_NZ : TEST_BIT_Z;
				result.source_reg  = instruction_word[4:0];
				result.wide_reg    = instruction_word[31];
				result.test_mask   = ADDR_W'(1) << bit_pos;
			end
			GRP_COND: begin
				offset = off19;
				if (cc < COND_ALWAYS_FIRST) begin
					result.branch_kind = KIND_COND;
					result.test_kind   = TEST_FLAGS;
					result.cond_code   = cc;
				end
			end
			GRP_REG: begin
				result.branch_kind = KIND_IND_JUMP;
				result.source_reg  = instruction_word[9:5];
				result.wide_reg    = 1'b1;
			end
			GRP_REGLNK: begin
				if (instruction_word[11] || (instruction_word[4:0] != 5'd0) || (op == OP_RSVD)) begin
					result.unallocated = 1'b1;
					result.link_value  = '0;
				end else begin
					case (op)
						OP_JUMP:   result.branch_kind = KIND_IND_JUMP;
						OP_CALL:   result.branch_kind = KIND_IND_CALL;
						OP_RETURN: result.branch_kind = KIND_RETURN;
						default:   result.branch_kind = KIND_UNCOND;
					endcase
					result.source_reg  = instruction_word[9:5];
					result.wide_reg    = 1'b1;
					result.writes_link = (op == OP_CALL);
				end
			end
			default: begin
				result.unallocated = 1'b1;
				result.link_value  = '0;
			end
		endcase
		if ((action == GRP_IMM) || (action == GRP_CMP) || (action == GRP_TST) ||
		    (action == GRP_COND)) begin
			result.target = pc + offset;
		end
	end

endmodule
